@@ src/wrist_and_gripper_drive_control_defines.svh @@
`ifndef WRIST_AND_GRIPPER_DRIVE_CONTROL_DEFINES_SVH
`define WRIST_AND_GRIPPER_DRIVE_CONTROL_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define WGDC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wgdc assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define WGDC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wgdc assertion failed");

`endif

@@ src/wgdc_pkg.sv @@
`default_nettype none

package wgdc_pkg;

   localparam int COUNT_WIDTH    = 32;
   localparam int POS_WIDTH      = 32;
   localparam int SUM_WIDTH      = ((COUNT_WIDTH > POS_WIDTH) ? COUNT_WIDTH : POS_WIDTH) + 2;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - 2;

   typedef logic [CSR_INDEX_WIDTH-1:0] reg_index_type;
   localparam reg_index_type REG_STEP_COUNTS      = 3'd0;
   localparam reg_index_type REG_TOLERANCE_COUNTS = 3'd1;
   localparam reg_index_type REG_GRIP_TIMEOUT_MS  = 3'd2;
   localparam reg_index_type REG_DRIVE_DUTY       = 3'd3;
   localparam reg_index_type REG_GRIP_DUTY        = 3'd4;

   localparam logic [15:0] STEP_COUNTS_RESET      = 16'd1004;
   localparam logic [15:0] TOLERANCE_COUNTS_RESET = 16'd100;
   localparam logic [15:0] GRIP_TIMEOUT_MS_RESET  = 16'd800;
   localparam logic [7:0]  DRIVE_DUTY_RESET       = 8'd100;
   localparam logic [7:0]  GRIP_DUTY_RESET        = 8'd255;

   typedef logic [1:0] func_type;
   localparam func_type FUNC_TICK  = 2'd0;
   localparam func_type FUNC_WRIST = 2'd1;
   localparam func_type FUNC_GRIP  = 2'd2;

   localparam int CMD_BEVEL_UP   = 0;
   localparam int CMD_BEVEL_DOWN = 1;
   localparam int CMD_LIFT_UP    = 2;
   localparam int CMD_LIFT_DOWN  = 3;
   localparam int CMD_CLOSE      = 4;
   localparam int CMD_OPEN       = 5;

   localparam logic signed [SUM_WIDTH-1:0] COUNT_MAX =
      {{(SUM_WIDTH-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] COUNT_MIN =
      {{(SUM_WIDTH-COUNT_WIDTH+1){1'b1}}, {(COUNT_WIDTH-1){1'b0}}};

   typedef struct packed {
      func_type                     func;
      logic [15:0]                  cmd_bits;
      logic signed [POS_WIDTH-1:0]  position_count;
      logic                         limit_up_pressed;
      logic                         limit_down_pressed;
      logic [31:0]                  now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0]                   motor_duty;
      logic                         motor_a_forward;
      logic                         motor_b_forward;
      logic [7:0]                   gripper_duty;
      logic                         gripper_closing;
      logic                         clear_encoders;
      logic                         any_limit;
      logic signed [POS_WIDTH-1:0]  reported_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] step_counts;
      logic [15:0] tolerance_counts;
      logic [15:0] grip_timeout_ms;
      logic [7:0]  drive_duty;
      logic [7:0]  grip_duty;
   } cfg_type;

   function automatic logic signed [COUNT_WIDTH-1:0] sat_count(
      input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] r;
      if (v > COUNT_MAX) begin
         r = COUNT_MAX;
      end else if (v < COUNT_MIN) begin
         r = COUNT_MIN;
      end else begin
         r = v;
      end
      return r[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic beyond_tol(
      input logic signed [SUM_WIDTH-1:0] pos,
      input logic signed [SUM_WIDTH-1:0] target,
      input logic [15:0]                 tol);
      logic signed [SUM_WIDTH-1:0] d;
      logic signed [SUM_WIDTH-1:0] t;
      d = pos - target;
      t = $signed({{(SUM_WIDTH-16){1'b0}}, tol});
      return (d > t) || (d < -t);
   endfunction

endpackage

`default_nettype wire

@@ src/wgdc_csr.sv @@
`default_nettype none

module wgdc_csr
   import wgdc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_STEP_COUNTS:      cfg_in.step_counts      = csr_pwdata[15:0];
            REG_TOLERANCE_COUNTS: cfg_in.tolerance_counts = csr_pwdata[15:0];
            REG_GRIP_TIMEOUT_MS:  cfg_in.grip_timeout_ms  = csr_pwdata[15:0];
            REG_DRIVE_DUTY:       cfg_in.drive_duty       = csr_pwdata[7:0];
            REG_GRIP_DUTY:        cfg_in.grip_duty        = csr_pwdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_STEP_COUNTS:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.step_counts);
         REG_TOLERANCE_COUNTS: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.tolerance_counts);
         REG_GRIP_TIMEOUT_MS:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.grip_timeout_ms);
         REG_DRIVE_DUTY:       csr_prdata = CSR_DATA_WIDTH'(cfg_ff.drive_duty);
         REG_GRIP_DUTY:        csr_prdata = CSR_DATA_WIDTH'(cfg_ff.grip_duty);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_counts      <= STEP_COUNTS_RESET;
         cfg_ff.tolerance_counts <= TOLERANCE_COUNTS_RESET;
         cfg_ff.grip_timeout_ms  <= GRIP_TIMEOUT_MS_RESET;
         cfg_ff.drive_duty       <= DRIVE_DUTY_RESET;
         cfg_ff.grip_duty        <= GRIP_DUTY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ src/wrist_and_gripper_drive_control.sv @@
// channel  | direction | handshake                  | word
// req      | in        | req_valid / req_ready      | req_type (tick, wrist or grip item)
// rsp      | out       | rsp_valid / rsp_ready      | rsp_type (one per control tick)
// csr      | in        | APB psel/penable, pready=1 | 32-bit register data
//
// one word per cycle sustained unless rsp stalls: a word sits in the input register,
// where all of its work is done, then its result is held in the output register.
// a control tick raises rsp_valid as its result moves into the output register.
// reset clears the handshake flags and loads the axis, gripper and register defaults.
// a stalled rsp holds the output register; req_ready drops only while the
// output register is full and not taken and the held word produces a result.
`default_nettype none

module wrist_and_gripper_drive_control
   import wgdc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   cfg_type cfg;

   wgdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_word_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   logic signed [COUNT_WIDTH-1:0] bevel_target_ff, bevel_target_in;
   logic signed [COUNT_WIDTH-1:0] lift_target_ff, lift_target_in;
   logic        bevel_active_ff, bevel_active_in;
   logic        lift_active_ff, lift_active_in;
   logic        bevel_positive_ff, bevel_positive_in;
   logic        lift_positive_ff, lift_positive_in;
   logic        grip_active_ff, grip_active_in;
   logic        grip_closing_dir_ff, grip_closing_dir_in;
   logic [31:0] grip_start_ms_ff, grip_start_ms_in;
   logic        pin_a_level_ff, pin_a_level_in;
   logic        pin_b_level_ff, pin_b_level_in;
   logic        pin_grip_level_ff, pin_grip_level_in;

   logic                          is_tick;
   logic                          advance;
   logic signed [SUM_WIDTH-1:0]   pos_ext;
   logic signed [SUM_WIDTH-1:0]   step_ext;
   logic signed [COUNT_WIDTH-1:0] target_up;
   logic signed [COUNT_WIDTH-1:0] target_down;
   logic                          cleared;
   logic signed [POS_WIDTH-1:0]   pos_eff;
   logic                          bevel_live;
   logic                          lift_live;
   logic                          bevel_drive;
   logic                          lift_drive;
   logic [31:0]                   elapsed;
   logic                          grip_expired;
   logic [15:0]                   cmd;

   assign is_tick   = (in_word_ff.func == FUNC_TICK);
   assign advance   = in_valid_ff && (!is_tick || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cmd       = in_word_ff.cmd_bits;

   assign pos_ext     = SUM_WIDTH'(in_word_ff.position_count);
   assign step_ext    = $signed({{(SUM_WIDTH-16){1'b0}}, cfg.step_counts});
   assign target_up   = sat_count(pos_ext + step_ext);
   assign target_down = sat_count(pos_ext - step_ext);

   assign cleared    = in_word_ff.limit_up_pressed && lift_active_ff && lift_positive_ff;
   assign pos_eff    = cleared ? '0 : in_word_ff.position_count;
   assign bevel_live = bevel_active_ff && !cleared;
   assign lift_live  = lift_active_ff && !cleared;
   assign bevel_drive = bevel_live && (cfg.drive_duty != '0) &&
      beyond_tol(SUM_WIDTH'(pos_eff), SUM_WIDTH'(bevel_target_ff), cfg.tolerance_counts);
   assign lift_drive = lift_live && (cfg.drive_duty != '0) &&
      beyond_tol(SUM_WIDTH'(pos_eff), SUM_WIDTH'(lift_target_ff), cfg.tolerance_counts);
   assign elapsed      = in_word_ff.now_ms - grip_start_ms_ff;
   assign grip_expired = elapsed > {16'd0, cfg.grip_timeout_ms};

   always_comb begin
      bevel_target_in     = bevel_target_ff;
      lift_target_in      = lift_target_ff;
      bevel_active_in     = bevel_active_ff;
      lift_active_in      = lift_active_ff;
      bevel_positive_in   = bevel_positive_ff;
      lift_positive_in    = lift_positive_ff;
      grip_active_in      = grip_active_ff;
      grip_closing_dir_in = grip_closing_dir_ff;
      grip_start_ms_in    = grip_start_ms_ff;
      pin_a_level_in      = pin_a_level_ff;
      pin_b_level_in      = pin_b_level_ff;
      pin_grip_level_in   = pin_grip_level_ff;
      rsp_data_in         = rsp_data_ff;

      if (advance) begin
         unique case (in_word_ff.func)
            FUNC_WRIST: begin
               bevel_active_in = cmd[CMD_BEVEL_UP] || cmd[CMD_BEVEL_DOWN];
               lift_active_in  = cmd[CMD_LIFT_UP] || cmd[CMD_LIFT_DOWN];
               if (cmd[CMD_BEVEL_DOWN]) begin
                  bevel_target_in   = target_down;
                  bevel_positive_in = 1'b0;
               end else if (cmd[CMD_BEVEL_UP]) begin
                  bevel_target_in   = target_up;
                  bevel_positive_in = 1'b1;
               end
               if (cmd[CMD_LIFT_DOWN]) begin
                  lift_target_in   = target_down;
                  lift_positive_in = 1'b0;
               end else if (cmd[CMD_LIFT_UP]) begin
                  lift_target_in   = target_up;
                  lift_positive_in = 1'b1;
               end
            end
            FUNC_GRIP: begin
               if (cmd[CMD_CLOSE] || cmd[CMD_OPEN]) begin
                  grip_closing_dir_in = !cmd[CMD_OPEN];
                  grip_active_in      = 1'b1;
                  grip_start_ms_in    = in_word_ff.now_ms;
               end
            end
            FUNC_TICK: begin
               bevel_active_in = bevel_live;
               lift_active_in  = lift_live;
               rsp_data_in.motor_duty = '0;
               if (lift_drive) begin
                  pin_a_level_in = lift_positive_ff;
                  pin_b_level_in = !lift_positive_ff;
                  rsp_data_in.motor_duty = cfg.drive_duty;
               end else if (bevel_drive) begin
                  pin_a_level_in = bevel_positive_ff;
                  pin_b_level_in = bevel_positive_ff;
                  rsp_data_in.motor_duty = cfg.drive_duty;
               end
               rsp_data_in.gripper_duty = '0;
               if (grip_active_ff) begin
                  if (grip_expired) begin
                     grip_active_in = 1'b0;
                  end else begin
                     pin_grip_level_in        = grip_closing_dir_ff;
                     rsp_data_in.gripper_duty = cfg.grip_duty;
                  end
               end
               rsp_data_in.motor_a_forward = pin_a_level_in;
               rsp_data_in.motor_b_forward = pin_b_level_in;
               rsp_data_in.gripper_closing = pin_grip_level_in;
               rsp_data_in.clear_encoders  = cleared;
               rsp_data_in.any_limit       =
                  in_word_ff.limit_up_pressed || in_word_ff.limit_down_pressed;
               rsp_data_in.reported_count  = pos_eff;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && is_tick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         bevel_target_ff     <= '0;
         lift_target_ff      <= '0;
         bevel_active_ff     <= 1'b0;
         lift_active_ff      <= 1'b0;
         bevel_positive_ff   <= 1'b1;
         lift_positive_ff    <= 1'b1;
         grip_active_ff      <= 1'b0;
         grip_closing_dir_ff <= 1'b1;
         grip_start_ms_ff    <= '0;
         pin_a_level_ff      <= 1'b0;
         pin_b_level_ff      <= 1'b0;
         pin_grip_level_ff   <= 1'b0;
      end else begin
         in_valid_ff         <= in_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         bevel_target_ff     <= bevel_target_in;
         lift_target_ff      <= lift_target_in;
         bevel_active_ff     <= bevel_active_in;
         lift_active_ff      <= lift_active_in;
         bevel_positive_ff   <= bevel_positive_in;
         lift_positive_ff    <= lift_positive_in;
         grip_active_ff      <= grip_active_in;
         grip_closing_dir_ff <= grip_closing_dir_in;
         grip_start_ms_ff    <= grip_start_ms_in;
         pin_a_level_ff      <= pin_a_level_in;
         pin_b_level_ff      <= pin_b_level_in;
         pin_grip_level_ff   <= pin_grip_level_in;
      end
   end

endmodule

`default_nettype wire

@@ src/wgdc_checker.sv @@
`default_nettype none
`include "wrist_and_gripper_drive_control_defines.svh"

module wgdc_checker
   import wgdc_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire rsp_type                   rsp_data
);

   // a held result word stays put until taken
   `WGDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // input stalls only behind a full, untaken output register
   `WGDC_ASSERT_NOW(a_req_stall, !req_ready, rsp_valid && !rsp_ready)

   // a limit reset stops the wrist and reports zero
   `WGDC_ASSERT_NOW(a_clear_stop, rsp_valid && rsp_data.clear_encoders,
      rsp_data.any_limit && rsp_data.motor_duty == 8'd0 && rsp_data.reported_count == '0)

   // nothing comes out right after reset
   `WGDC_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid)

endmodule

bind wrist_and_gripper_drive_control wgdc_checker u_wgdc_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import wgdc_pkg::*;

   localparam func_type FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 195;

   class drive_scoreboard;
      logic [15:0] step_counts = STEP_COUNTS_RESET;
      logic [15:0] tolerance_counts = TOLERANCE_COUNTS_RESET;
      logic [15:0] grip_timeout_ms = GRIP_TIMEOUT_MS_RESET;
      logic [7:0] drive_duty = DRIVE_DUTY_RESET;
      logic [7:0] grip_duty = GRIP_DUTY_RESET;

      logic signed [31:0] bevel_goal = '0;
      logic signed [31:0] lift_goal = '0;
      bit bevel_on = 1'b0;
      bit lift_on = 1'b0;
      bit bevel_up_dir = 1'b1;
      bit lift_up_dir = 1'b1;
      bit grip_on = 1'b0;
      bit grip_close_dir = 1'b1;
      logic [31:0] grip_t0 = '0;
      bit pin_a = 1'b0;
      bit pin_b = 1'b0;
      bit pin_g = 1'b0;

      rsp_type owed_rsp[$];
      int mismatches = 0;

      function int pending();
         return owed_rsp.size();
      endfunction

      function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, act_v, $realtime);
         end
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] v);
         case (idx)
            REG_STEP_COUNTS: step_counts = v[15:0];
            REG_TOLERANCE_COUNTS: tolerance_counts = v[15:0];
            REG_GRIP_TIMEOUT_MS: grip_timeout_ms = v[15:0];
            REG_DRIVE_DUTY: drive_duty = v[7:0];
            REG_GRIP_DUTY: grip_duty = v[7:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(reg_index_type idx);
         case (idx)
            REG_STEP_COUNTS: return {16'd0, step_counts};
            REG_TOLERANCE_COUNTS: return {16'd0, tolerance_counts};
            REG_GRIP_TIMEOUT_MS: return {16'd0, grip_timeout_ms};
            REG_DRIVE_DUTY: return {24'd0, drive_duty};
            REG_GRIP_DUTY: return {24'd0, grip_duty};
            default: return '0;
         endcase
      endfunction

      function logic signed [31:0] clamp_count(logic signed [33:0] v);
         if (v > 34'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -34'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function logic signed [31:0] aim(logic signed [31:0] pos, bit up);
         logic signed [33:0] st;
         logic signed [33:0] s;
         st = $signed({18'd0, step_counts});
         s = up ? pos + st : pos - st;
         return clamp_count(s);
      endfunction

      function bit far_from(logic signed [31:0] pos, logic signed [31:0] goal);
         logic signed [33:0] d;
         d = pos - goal;
         if (d < 0) d = -d;
         return d > $signed({18'd0, tolerance_counts});
      endfunction

      function void note_request(req_type w);
         logic signed [31:0] pos;
         logic [31:0] elapsed;
         bit cleared;
         bit bevel_go;
         bit lift_go;
         rsp_type r;
         case (w.func)
            FUNC_WRIST: begin
               bevel_on = 1'b0;
               lift_on = 1'b0;
               if (w.cmd_bits[CMD_BEVEL_UP]) begin
                  bevel_goal = aim(w.position_count, 1'b1);
                  bevel_up_dir = 1'b1;
                  bevel_on = 1'b1;
               end
               if (w.cmd_bits[CMD_BEVEL_DOWN]) begin
                  bevel_goal = aim(w.position_count, 1'b0);
                  bevel_up_dir = 1'b0;
                  bevel_on = 1'b1;
               end
               if (w.cmd_bits[CMD_LIFT_UP]) begin
                  lift_goal = aim(w.position_count, 1'b1);
                  lift_up_dir = 1'b1;
                  lift_on = 1'b1;
               end
               if (w.cmd_bits[CMD_LIFT_DOWN]) begin
                  lift_goal = aim(w.position_count, 1'b0);
                  lift_up_dir = 1'b0;
                  lift_on = 1'b1;
               end
            end
            FUNC_GRIP: begin
               if (w.cmd_bits[CMD_CLOSE]) begin
                  grip_close_dir = 1'b1;
                  grip_on = 1'b1;
                  grip_t0 = w.now_ms;
               end
               if (w.cmd_bits[CMD_OPEN]) begin
                  grip_close_dir = 1'b0;
                  grip_on = 1'b1;
                  grip_t0 = w.now_ms;
               end
            end
            FUNC_TICK: begin
               pos = w.position_count;
               cleared = w.limit_up_pressed && lift_on && lift_up_dir;
               if (cleared) begin
                  lift_on = 1'b0;
                  bevel_on = 1'b0;
                  pos = '0;
               end
               bevel_go = bevel_on && drive_duty != 0 && far_from(pos, bevel_goal);
               lift_go = lift_on && drive_duty != 0 && far_from(pos, lift_goal);
               r = '0;
               if (lift_go) begin
                  pin_a = lift_up_dir;
                  pin_b = !lift_up_dir;
                  r.motor_duty = drive_duty;
               end else if (bevel_go) begin
                  pin_a = bevel_up_dir;
                  pin_b = bevel_up_dir;
                  r.motor_duty = drive_duty;
               end
               if (grip_on) begin
                  elapsed = w.now_ms - grip_t0;
                  if (elapsed > {16'd0, grip_timeout_ms}) begin
                     grip_on = 1'b0;
                  end else begin
                     pin_g = grip_close_dir;
                     r.gripper_duty = grip_duty;
                  end
               end
               r.motor_a_forward = pin_a;
               r.motor_b_forward = pin_b;
               r.gripper_closing = pin_g;
               r.clear_encoders = cleared;
               r.any_limit = w.limit_up_pressed || w.limit_down_pressed;
               r.reported_count = pos;
               owed_rsp.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (owed_rsp.size() == 0) begin
            flag("rsp word with nothing expected", '0, got.reported_count);
            return;
         end
         want = owed_rsp.pop_front();
         if (got.motor_duty !== want.motor_duty)
            flag("motor_duty", 32'(want.motor_duty), 32'(got.motor_duty));
         if (got.motor_a_forward !== want.motor_a_forward)
            flag("motor_a_forward", 32'(want.motor_a_forward), 32'(got.motor_a_forward));
         if (got.motor_b_forward !== want.motor_b_forward)
            flag("motor_b_forward", 32'(want.motor_b_forward), 32'(got.motor_b_forward));
         if (got.gripper_duty !== want.gripper_duty)
            flag("gripper_duty", 32'(want.gripper_duty), 32'(got.gripper_duty));
         if (got.gripper_closing !== want.gripper_closing)
            flag("gripper_closing", 32'(want.gripper_closing), 32'(got.gripper_closing));
         if (got.clear_encoders !== want.clear_encoders)
            flag("clear_encoders", 32'(want.clear_encoders), 32'(got.clear_encoders));
         if (got.any_limit !== want.any_limit)
            flag("any_limit", 32'(want.any_limit), 32'(got.any_limit));
         if (got.reported_count !== want.reported_count)
            flag("reported_count", want.reported_count, got.reported_count);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   drive_scoreboard board;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int cycle_count;
   logic signed [31:0] cur_pos;
   logic [31:0] cur_now;

   wrist_and_gripper_drive_control dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL wrist_and_gripper_drive_control");
      $finish;
   end

   // result side: random stalls plus a long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) board.check_rsp(rsp_data);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic push_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      board.note_request(w);
   endtask

   // write, then read back the same register
   task automatic csr_write(input reg_index_type idx, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_reg(idx, v);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== board.reg_value(idx))
         board.flag("register readback", board.reg_value(idx), csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input cfg_type c);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_STEP_COUNTS, {16'd0, c.step_counts});
      csr_write(REG_TOLERANCE_COUNTS, {16'd0, c.tolerance_counts});
      csr_write(REG_GRIP_TIMEOUT_MS, {16'd0, c.grip_timeout_ms});
      csr_write(REG_DRIVE_DUTY, {24'd0, c.drive_duty});
      csr_write(REG_GRIP_DUTY, {24'd0, c.grip_duty});
   endtask

   function automatic cfg_type settings_for(int phase);
      cfg_type c;
      case (phase)
         0: c = '{STEP_COUNTS_RESET, TOLERANCE_COUNTS_RESET, GRIP_TIMEOUT_MS_RESET,
                  DRIVE_DUTY_RESET, GRIP_DUTY_RESET};
         1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF};
         2: c = '{16'd1, 16'd0, 16'd0, 8'd0, 8'd0};
         4: c = '{16'd1, 16'd0, 16'd1, 8'd1, 8'd1};
         default: begin
            c.step_counts = 16'($urandom_range(4000, 1));
            c.tolerance_counts = 16'($urandom_range(300));
            c.grip_timeout_ms = 16'($urandom_range(2000));
            c.drive_duty = 8'($urandom_range(255));
            c.grip_duty = 8'($urandom_range(255));
         end
      endcase
      return c;
   endfunction

   function automatic req_type make_word(func_type f, logic [15:0] c, logic [31:0] p,
                                         bit u, bit d, logic [31:0] n);
      req_type w;
      w.func = f;
      w.cmd_bits = c;
      w.position_count = p;
      w.limit_up_pressed = u;
      w.limit_down_pressed = d;
      w.now_ms = n;
      return w;
   endfunction

   task automatic random_word(output req_type w);
      logic [31:0] s;
      logic [31:0] offset;
      int r;
      s = {16'd0, board.step_counts};
      r = $urandom_range(99);
      case ($urandom_range(9))
         0: cur_pos = $urandom;
         1: begin
            offset = {16'd0, board.tolerance_counts} + $urandom_range(1);
            cur_pos = ($urandom_range(1) ? board.lift_goal : board.bevel_goal)
                      + ($urandom_range(1) ? offset : -offset);
         end
         2: cur_pos = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: cur_pos = cur_pos + $urandom_range(2 * s) - s;
      endcase
      case ($urandom_range(7))
         0: cur_now = $urandom;
         1: cur_now = board.grip_t0 + {16'd0, board.grip_timeout_ms} + $urandom_range(1);
         default: cur_now = cur_now + $urandom_range(300);
      endcase
      w.cmd_bits = 16'($urandom);
      w.position_count = cur_pos;
      w.limit_up_pressed = ($urandom_range(5) == 0);
      w.limit_down_pressed = ($urandom_range(5) == 0);
      w.now_ms = cur_now;
      if (r < 12) begin
         w.func = FUNC_WRIST;
         if ($urandom_range(1)) w.cmd_bits[3:0] = 4'h1 << $urandom_range(3);
      end else if (r < 20) begin
         w.func = FUNC_GRIP;
      end else if (r < 23) begin
         w.func = FUNC_UNUSED;
      end else begin
         w.func = FUNC_TICK;
      end
   endtask

   initial begin
      req_type w;
      int useful;
      logic [15:0] bevel_up_cmd;
      logic [15:0] bevel_down_cmd;
      logic [15:0] lift_up_cmd;
      logic [15:0] lift_down_cmd;
      logic [15:0] close_cmd;
      logic [15:0] open_cmd;
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      cur_pos = '0;
      cur_now = '0;
      bevel_up_cmd = 16'h1 << CMD_BEVEL_UP;
      bevel_down_cmd = 16'h1 << CMD_BEVEL_DOWN;
      lift_up_cmd = 16'h1 << CMD_LIFT_UP;
      lift_down_cmd = 16'h1 << CMD_LIFT_DOWN;
      close_cmd = 16'h1 << CMD_CLOSE;
      open_cmd = 16'h1 << CMD_OPEN;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      apply_settings(settings_for(0));

      // directed words: saturation, tolerance, limit clear, overrides, timer wrap
      push_word(make_word(FUNC_TICK, 16'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'd0));
      push_word(make_word(FUNC_WRIST, bevel_up_cmd, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b0, 1'b0, 32'd1));
      push_word(make_word(FUNC_WRIST, bevel_down_cmd, 32'h8000_0000, 1'b0, 1'b0, 32'd2));
      push_word(make_word(FUNC_TICK, 16'h0, 32'h8000_0000, 1'b0, 1'b0, 32'd3));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b0, 1'b0, 32'd4));
      push_word(make_word(FUNC_WRIST, bevel_up_cmd | bevel_down_cmd | lift_up_cmd
                          | lift_down_cmd, 32'd0, 1'b0, 1'b0, 32'd5));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd5000, 1'b0, 1'b0, 32'd6));
      push_word(make_word(FUNC_WRIST, lift_up_cmd, 32'd0, 1'b0, 1'b0, 32'd7));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd1004, 1'b0, 1'b0, 32'd8));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd2000, 1'b0, 1'b0, 32'd9));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd2000, 1'b1, 1'b0, 32'd10));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd2000, 1'b0, 1'b0, 32'd11));
      push_word(make_word(FUNC_WRIST, lift_down_cmd, 32'd0, 1'b0, 1'b0, 32'd12));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b1, 1'b1, 32'd13));
      push_word(make_word(FUNC_WRIST, 16'h0, 32'd0, 1'b0, 1'b0, 32'd14));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd9999, 1'b0, 1'b0, 32'd15));
      push_word(make_word(FUNC_GRIP, close_cmd, 32'd0, 1'b0, 1'b0, 32'hFFFF_FF00));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b0, 1'b0, 32'h0000_0100));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FF00 + 32'd800));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FF00 + 32'd801));
      push_word(make_word(FUNC_GRIP, close_cmd | open_cmd, 32'd0, 1'b0, 1'b0, 32'd5));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b0, 1'b0, 32'd5));
      push_word(make_word(FUNC_GRIP, ~(close_cmd | open_cmd), 32'd0, 1'b0, 1'b0, 32'd9));
      push_word(make_word(FUNC_TICK, 16'h0, 32'd0, 1'b0, 1'b0, 32'd806));
      push_word(make_word(FUNC_UNUSED, 16'hFFFF, $urandom, 1'b1, 1'b1, $urandom));

      for (int phase = 0; phase < PHASES; phase++) begin
         apply_settings(settings_for(phase));
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 49;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 49;
            end
            default: begin
               send_idle_pct = 20;
               recv_stall_pct = 20;
            end
         endcase
         useful = 0;
         while (useful < WORDS_PER_PHASE) begin
            if (phase == 0 && useful == 60) hold_cycles = 300;
            if (phase == 2 && useful == 100) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (board.pending() != 0);
            end
            random_word(w);
            push_word(w);
            if (w.func != FUNC_UNUSED) useful++;
         end
      end

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("PASS wrist_and_gripper_drive_control");
      end else begin
         $display("FAIL wrist_and_gripper_drive_control");
      end
      $finish;
   end

endmodule
